// ----- rtl/core/sild_pkg.sv -----
package sild_pkg;

  // Default width of code offsets.
  localparam int OFFSET_BITS_DEFAULT = 16;

  // Opcode table limits and special operand forms.
  localparam int unsigned OPCODE_COUNT = 80;
  localparam logic [7:0] FORM_STRING = 8'h80;
  localparam logic [7:0] FORM_CHOICE = 8'h81;
  localparam logic [6:0] CHOICE_OPCODE = 7'd31;

  // String commands that carry a prefix before their text.
  localparam logic [6:0] OP_PREFIX2_A = 7'd13;
  localparam logic [6:0] OP_PREFIX2_B = 7'd64;
  localparam logic [6:0] OP_PREFIX2_C = 7'd69;
  localparam logic [6:0] OP_PREFIX4 = 7'd61;

  // Number of address bytes after the second CHOICE string.
  localparam logic [4:0] CHOICE_ADDR_BYTES = 5'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_COUNT,
    PH_PREFIX,
    PH_STRING
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BADOP,
    ST_PAST
  } status_t;

  // One decoded command as it leaves the sequencer.
  typedef struct packed {
    status_t     status;
    logic [7:0]  opcode;
    logic [15:0] command_offset;
    logic [15:0] operand_offset;
    logic [15:0] operand_length;
    logic [15:0] next_offset;
  } result_t;

  // Operand form of every opcode: a byte count, or one of the string forms.
  localparam logic [7:0] FORM_TABLE [OPCODE_COUNT] = '{
    8'd4, 8'd8, 8'd6, 8'd2, 8'd2, 8'd4, 8'd6, 8'd6, 8'd4, 8'd0,
    8'd2, 8'd4, 8'd4, FORM_STRING, 8'd4, 8'd1, 8'd4, 8'd1, 8'd2, 8'd4,
    8'd0, 8'd6, 8'd4, 8'd4, 8'd2, 8'd4, 8'd2, 8'd2, FORM_STRING, 8'd4,
    8'd10, FORM_CHOICE, 8'd8, 8'd2, 8'd4, 8'd22, 8'd0, 8'd0, 8'd8, 8'd30,
    8'd2, 8'd4, 8'd4, 8'd4, 8'd6, 8'd0, 8'd4, FORM_STRING, 8'd6, 8'd4,
    8'd4, 8'd2, 8'd0, 8'd6, FORM_STRING, 8'd0, 8'd0, 8'd6, 8'd10, 8'd6,
    8'd6, FORM_STRING, 8'd8, 8'd4, FORM_STRING, 8'd6, 8'd4, 8'd8, 8'd0,
    FORM_STRING, 8'd0, 8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'd4, 8'd10, 8'd2, 8'd2
  };

  // Operand form lookup; opcodes past the table read as zero.
  function automatic logic [7:0] operand_form(input logic [6:0] op);
    logic [7:0] form;
    form = 8'd0;
    if (op < 7'(OPCODE_COUNT)) begin
      form = FORM_TABLE[op];
    end
    return form;
  endfunction

  // Prefix length of a string command.
  function automatic logic [2:0] prefix_length(input logic [6:0] op);
    logic [2:0] len;
    unique case (op)
      OP_PREFIX2_A, OP_PREFIX2_B, OP_PREFIX2_C: len = 3'd2;
      OP_PREFIX4: len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/sild_step.sv -----
module sild_step #(
  parameter int OFFSET_BITS = sild_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [OFFSET_BITS-1:0] code_size,
  input  logic                   step,
  input  logic [7:0]             code_byte,
  input  logic                   begin_req,
  input  logic [OFFSET_BITS-1:0] start_offset,
  output logic                   res_valid,
  output sild_pkg::result_t      res
);

  localparam int W = OFFSET_BITS + 1;

  // Sequencer state.
  sild_pkg::phase_t       phase, phase_next;
  logic [OFFSET_BITS-1:0] current_offset, current_offset_next;
  logic [OFFSET_BITS-1:0] command_start, command_start_next;
  logic [6:0]             current_opcode, current_opcode_next;
  logic [4:0]             bytes_left, bytes_left_next;
  logic [1:0]             strings_left, strings_left_next;

  logic [OFFSET_BITS-1:0] off;
  logic [W-1:0]           off_x, off_p1, size_x;
  logic [7:0]             form;
  logic [2:0]             prefix;
  logic [4:0]             bytes_dec;
  logic [1:0]             strings_dec;
  logic                   emit;
  sild_pkg::status_t      emit_status;
  logic [7:0]             emit_opcode;
  logic [OFFSET_BITS-1:0] emit_next;
  logic [15:0]            cmd16, next16;

  assign off    = begin_req ? start_offset : current_offset;
  assign off_x  = {1'b0, off};
  assign off_p1 = off_x + W'(1);
  assign size_x = {1'b0, code_size};
  assign form   = sild_pkg::operand_form(code_byte[6:0]);
  assign prefix = sild_pkg::prefix_length(code_byte[6:0]);
  assign bytes_dec   = (bytes_left != 5'd0) ? bytes_left - 5'd1 : 5'd0;
  assign strings_dec = (strings_left != 2'd0) ? strings_left - 2'd1 : 2'd0;

  // Per-byte decode: table lookup, bound checks and counter updates.
  always_comb begin
    phase_next          = phase;
    current_offset_next = current_offset;
    command_start_next  = command_start;
    current_opcode_next = current_opcode;
    bytes_left_next     = bytes_left;
    strings_left_next   = strings_left;
    emit        = 1'b0;
    emit_status = sild_pkg::ST_OK;
    emit_opcode = {1'b0, current_opcode};
    emit_next   = off_p1[OFFSET_BITS-1:0];

    if (begin_req || phase == sild_pkg::PH_OPCODE) begin
      // This byte is an opcode.
      command_start_next = off;
      emit_opcode = code_byte;
      if (off_x >= size_x) begin
        emit = 1'b1;
        emit_status = sild_pkg::ST_PAST;
      end else if (code_byte >= 8'(sild_pkg::OPCODE_COUNT)) begin
        emit = 1'b1;
        emit_status = sild_pkg::ST_BADOP;
      end else begin
        current_opcode_next = code_byte[6:0];
        current_offset_next = off_p1[OFFSET_BITS-1:0];
        if (form < sild_pkg::FORM_STRING) begin
          if (off_p1 + W'(form) > size_x) begin
            emit = 1'b1;
            emit_status = sild_pkg::ST_PAST;
          end else if (form == 8'd0) begin
            emit = 1'b1;
          end else begin
            bytes_left_next = form[4:0];
            phase_next = sild_pkg::PH_COUNT;
          end
        end else if (form == sild_pkg::FORM_CHOICE) begin
          if (off_p1 >= size_x) begin
            emit = 1'b1;
            emit_status = sild_pkg::ST_PAST;
          end else begin
            strings_left_next = 2'd2;
            phase_next = sild_pkg::PH_STRING;
          end
        end else begin
          if (off_p1 + W'(prefix) >= size_x) begin
            emit = 1'b1;
            emit_status = sild_pkg::ST_PAST;
          end else begin
            strings_left_next = 2'd1;
            bytes_left_next = 5'(prefix);
            phase_next = (prefix != 3'd0) ? sild_pkg::PH_PREFIX : sild_pkg::PH_STRING;
          end
        end
      end
    end else begin
      unique case (phase)
        sild_pkg::PH_COUNT: begin
          current_offset_next = off_p1[OFFSET_BITS-1:0];
          bytes_left_next = bytes_dec;
          if (bytes_dec == 5'd0) begin
            emit = 1'b1;
          end
        end
        sild_pkg::PH_PREFIX: begin
          current_offset_next = off_p1[OFFSET_BITS-1:0];
          bytes_left_next = bytes_dec;
          if (bytes_dec == 5'd0) begin
            phase_next = sild_pkg::PH_STRING;
          end
        end
        sild_pkg::PH_STRING: begin
          if (code_byte != 8'd0) begin
            // A string byte must leave room for its terminator.
            if (off_p1 >= size_x) begin
              emit = 1'b1;
              emit_status = sild_pkg::ST_PAST;
            end else begin
              current_offset_next = off_p1[OFFSET_BITS-1:0];
            end
          end else begin
            current_offset_next = off_p1[OFFSET_BITS-1:0];
            strings_left_next = strings_dec;
            if (strings_dec != 2'd0) begin
              if (off_p1 >= size_x) begin
                emit = 1'b1;
                emit_status = sild_pkg::ST_PAST;
              end
            end else if (current_opcode == sild_pkg::CHOICE_OPCODE) begin
              // Two address bytes follow the second CHOICE string.
              if (off_x + W'(3) > size_x) begin
                emit = 1'b1;
                emit_status = sild_pkg::ST_PAST;
              end else begin
                bytes_left_next = sild_pkg::CHOICE_ADDR_BYTES;
                phase_next = sild_pkg::PH_COUNT;
              end
            end else begin
              emit = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // A finished command chains to the next opcode; an error waits for begin.
    if (emit) begin
      if (emit_status == sild_pkg::ST_OK) begin
        phase_next = sild_pkg::PH_OPCODE;
        current_offset_next = emit_next;
      end else begin
        phase_next = sild_pkg::PH_IDLE;
      end
    end
  end

  // Result fields.
  assign cmd16  = 16'(command_start_next);
  assign next16 = 16'(emit_next);

  always_comb begin
    res_valid          = step && emit;
    res.status         = emit_status;
    res.opcode         = emit_opcode;
    res.command_offset = cmd16;
    res.operand_offset = cmd16 + 16'd1;
    if (emit_status == sild_pkg::ST_OK) begin
      res.operand_length = next16 - cmd16 - 16'd1;
      res.next_offset    = next16;
    end else begin
      res.operand_length = 16'd0;
      res.next_offset    = 16'd0;
    end
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sild_pkg::PH_IDLE;
      current_offset <= '0;
      command_start  <= '0;
      current_opcode <= '0;
      bytes_left     <= '0;
      strings_left   <= '0;
    end else if (step) begin
      phase          <= phase_next;
      current_offset <= current_offset_next;
      command_start  <= command_start_next;
      current_opcode <= current_opcode_next;
      bytes_left     <= bytes_left_next;
      strings_left   <= strings_left_next;
    end
  end

endmodule

// ----- rtl/core/script_instruction_length_decoder_core.sv -----
// Timing: a code byte accepted into the input register is processed when the
// output register can take a result, and any result is then registered there.
// Throughput: one code byte per cycle unless the output register stalls. The
// per-byte decode: one opcode table pass, the bound compares and counter updates.
// Reset (rst, synchronous, active high) empties both registers, clears
// code_size and returns the decoder to waiting for a begin request.
module script_instruction_length_decoder_core #(
  parameter int OFFSET_BITS = sild_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        begin_req,
  input  logic [15:0] start_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  opcode_out,
  output logic [15:0] command_offset,
  output logic [15:0] operand_offset,
  output logic [15:0] operand_length,
  output logic [15:0] next_offset
);

  logic [15:0]            code_size;
  logic                   in_full;
  logic [7:0]             byte_r;
  logic                   begin_r;
  logic [OFFSET_BITS-1:0] start_r;
  logic                   fire;
  logic                   res_valid;
  sild_pkg::result_t      res;
  sild_pkg::result_t      out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_size <= '0;
    end else if (cfg_we) begin
      code_size <= cfg_wdata;
    end
  end

  // The held byte is processed when the output register can take a result.
  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= code_byte;
      begin_r <= begin_req;
      start_r <= start_offset[OFFSET_BITS-1:0];
    end
  end

  sild_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .code_size   (code_size[OFFSET_BITS-1:0]),
    .step        (fire),
    .code_byte   (byte_r),
    .begin_req   (begin_r),
    .start_offset(start_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register holds one transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign status         = out_r.status;
  assign opcode_out     = out_r.opcode;
  assign command_offset = out_r.command_offset;
  assign operand_offset = out_r.operand_offset;
  assign operand_length = out_r.operand_length;
  assign next_offset    = out_r.next_offset;

endmodule

// ----- test/command_tracker_pkg.sv -----
`timescale 1ns / 100ps
package command_tracker_pkg;
  import sild_pkg::*;

  // Operand bytes for each opcode, or one of the two string forms.
  localparam logic [7:0] OPERAND_FORM [OPCODE_COUNT] = '{
    8'd4, 8'd8, 8'd6, 8'd2, 8'd2, 8'd4, 8'd6, 8'd6, 8'd4, 8'd0,
    8'd2, 8'd4, 8'd4, FORM_STRING, 8'd4, 8'd1, 8'd4, 8'd1, 8'd2, 8'd4,
    8'd0, 8'd6, 8'd4, 8'd4, 8'd2, 8'd4, 8'd2, 8'd2, FORM_STRING, 8'd4,
    8'd10, FORM_CHOICE, 8'd8, 8'd2, 8'd4, 8'd22, 8'd0, 8'd0, 8'd8, 8'd30,
    8'd2, 8'd4, 8'd4, 8'd4, 8'd6, 8'd0, 8'd4, FORM_STRING, 8'd6, 8'd4,
    8'd4, 8'd2, 8'd0, 8'd6, FORM_STRING, 8'd0, 8'd0, 8'd6, 8'd10, 8'd6,
    8'd6, FORM_STRING, 8'd8, 8'd4, FORM_STRING, 8'd6, 8'd4, 8'd8, 8'd0,
    FORM_STRING, 8'd0, 8'd0, 8'd0, 8'd4, 8'd0, 8'd0, 8'd4, 8'd10, 8'd2, 8'd2
  };

  // Number of bytes ahead of the text of a string command.
  function automatic int unsigned text_prefix(input logic [7:0] op);
    int unsigned n;
    n = 0;
    if (op[6:0] == OP_PREFIX4 && op[7] == 1'b0) begin
      n = 4;
    end else if (op[7] == 1'b0 && (op[6:0] == OP_PREFIX2_A || op[6:0] == OP_PREFIX2_B ||
                                   op[6:0] == OP_PREFIX2_C)) begin
      n = 2;
    end
    return n;
  endfunction

  // Tracks the decoder state byte by byte and holds the commands it must report.
  class command_tracker;
    logic [15:0] code_size;
    phase_t      phase;
    logic [16:0] cur_off;
    logic [15:0] cmd_start;
    logic [6:0]  cur_op;
    logic [4:0]  bytes_left;
    logic [1:0]  strings_left;
    result_t     expected[$];
    int          mismatches;
    int          checked;
    int          status_seen[3];

    function new();
      code_size = '0;
      phase = PH_IDLE;
      cur_off = '0;
      cmd_start = '0;
      cur_op = '0;
      bytes_left = '0;
      strings_left = '0;
      mismatches = 0;
      checked = 0;
      status_seen = '{0, 0, 0};
    endfunction

    // Queue the result of a finished or failed command.
    function void close_command(input status_t st, input logic [7:0] op,
                                input logic [16:0] nxt);
      result_t r;
      r.status = st;
      r.opcode = op;
      r.command_offset = cmd_start;
      r.operand_offset = cmd_start + 16'd1;
      if (st == ST_OK) begin
        r.operand_length = nxt[15:0] - cmd_start - 16'd1;
        r.next_offset = nxt[15:0];
        phase = PH_OPCODE;
        cur_off = nxt;
      end else begin
        r.operand_length = '0;
        r.next_offset = '0;
        phase = PH_IDLE;
      end
      expected.push_back(r);
    endfunction

    // Decode an opcode byte at the given offset.
    function void open_command(input logic [7:0] op, input logic [16:0] off);
      int unsigned o;
      int unsigned sz;
      int unsigned form;
      int unsigned pre;
      o = off;
      sz = code_size;
      cmd_start = off[15:0];
      if (o >= sz) begin
        close_command(ST_PAST, op, '0);
      end else if (op >= OPCODE_COUNT) begin
        close_command(ST_BADOP, op, '0);
      end else begin
        cur_op = op[6:0];
        form = OPERAND_FORM[op[6:0]];
        cur_off = off + 17'd1;
        if (form == FORM_CHOICE) begin
          if (o + 1 >= sz) begin
            close_command(ST_PAST, op, '0);
          end else begin
            strings_left = 2'd2;
            phase = PH_STRING;
          end
        end else if (form == FORM_STRING) begin
          pre = text_prefix(op);
          if (o + 1 + pre >= sz) begin
            close_command(ST_PAST, op, '0);
          end else begin
            strings_left = 2'd1;
            bytes_left = 5'(pre);
            phase = (pre != 0) ? PH_PREFIX : PH_STRING;
          end
        end else if (o + 1 + form > sz) begin
          close_command(ST_PAST, op, '0);
        end else if (form == 0) begin
          close_command(ST_OK, op, off + 17'd1);
        end else begin
          bytes_left = 5'(form);
          phase = PH_COUNT;
        end
      end
    endfunction

    // Note one accepted input transaction; returns 0 when the byte is ignored.
    function bit note_code_byte(input logic [7:0] b, input logic bg, input logic [15:0] so);
      bit used;
      logic [16:0] off_now;
      int unsigned o;
      int unsigned sz;
      used = bg || (phase != PH_IDLE);
      off_now = cur_off;
      o = off_now;
      sz = code_size;
      if (bg) begin
        open_command(b, {1'b0, so});
      end else begin
        case (phase)
          PH_OPCODE: open_command(b, off_now);
          PH_COUNT: begin
            cur_off = off_now + 17'd1;
            if (bytes_left != 0) bytes_left--;
            if (bytes_left == 0) close_command(ST_OK, {1'b0, cur_op}, off_now + 17'd1);
          end
          PH_PREFIX: begin
            cur_off = off_now + 17'd1;
            if (bytes_left != 0) bytes_left--;
            if (bytes_left == 0) phase = PH_STRING;
          end
          PH_STRING: begin
            if (b != 8'h00) begin
              // A text byte must leave room for at least its terminator.
              if (o + 1 >= sz) begin
                close_command(ST_PAST, {1'b0, cur_op}, '0);
              end else begin
                cur_off = off_now + 17'd1;
              end
            end else begin
              cur_off = off_now + 17'd1;
              if (strings_left != 0) strings_left--;
              if (strings_left != 0) begin
                if (o + 1 >= sz) close_command(ST_PAST, {1'b0, cur_op}, '0);
              end else if (cur_op == CHOICE_OPCODE) begin
                // The second text is followed by the branch address.
                if (o + 3 > sz) begin
                  close_command(ST_PAST, {1'b0, cur_op}, '0);
                end else begin
                  bytes_left = CHOICE_ADDR_BYTES;
                  phase = PH_COUNT;
                end
              end else begin
                close_command(ST_OK, {1'b0, cur_op}, off_now + 17'd1);
              end
            end
          end
          default: ;
        endcase
      end
      return used;
    endfunction

    // Print one line per mismatch, up to a cap, and count them all.
    task report(input string msg);
      mismatches++;
      if (mismatches <= 60) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Compare one accepted result transaction with the oldest expected command.
    task check_command(input logic [1:0] st, input logic [7:0] op, input logic [15:0] cmd_off,
                       input logic [15:0] opnd_off, input logic [15:0] opnd_len,
                       input logic [15:0] nxt);
      result_t want;
      if (expected.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d opcode %0d offset %0d",
                         st, op, cmd_off));
      end else begin
        want = expected.pop_front();
        checked++;
        status_seen[int'(want.status)]++;
        if (st !== want.status)
          report($sformatf("status %0d, expected %0d (command at %0d)",
                           st, want.status, want.command_offset));
        if (op !== want.opcode)
          report($sformatf("opcode %0d, expected %0d (command at %0d)",
                           op, want.opcode, want.command_offset));
        if (cmd_off !== want.command_offset)
          report($sformatf("command offset %0d, expected %0d", cmd_off, want.command_offset));
        if (opnd_off !== want.operand_offset)
          report($sformatf("operand offset %0d, expected %0d (command at %0d)",
                           opnd_off, want.operand_offset, want.command_offset));
        if (opnd_len !== want.operand_length)
          report($sformatf("operand length %0d, expected %0d (command at %0d)",
                           opnd_len, want.operand_length, want.command_offset));
        if (nxt !== want.next_offset)
          report($sformatf("next offset %0d, expected %0d (command at %0d)",
                           nxt, want.next_offset, want.command_offset));
      end
    endtask
  endclass

endpackage

// ----- test/script_instruction_length_decoder_core_tb.sv -----
`timescale 1ns / 100ps
module script_instruction_length_decoder_core_tb;
  import sild_pkg::*;
  import command_tracker_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SIZE_PHASES = 12;
  localparam int HOLD_CYCLES = 400;

  // Opcodes used by name in the directed part.
  localparam logic [7:0] OP_NO_OPERANDS = 8'd9;
  localparam logic [7:0] OP_FIXED8 = 8'd1;
  localparam logic [7:0] OP_LONG_FIXED = 8'd35;
  localparam logic [7:0] OP_TEXT = 8'd28;
  localparam logic [7:0] OP_CHOICE = 8'(CHOICE_OPCODE);
  localparam logic [7:0] OP_TEXT_PRE2 = 8'(OP_PREFIX2_A);
  localparam logic [7:0] OP_TEXT_PRE4 = 8'(OP_PREFIX4);
  localparam logic [7:0] OP_FIRST_BAD = 8'(OPCODE_COUNT);
  localparam logic [7:0] TEXT_OPS [7] = '{8'd13, 8'd28, 8'd47, 8'd54, 8'd61, 8'd64, 8'd69};

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  code_byte = '0;
  logic        begin_req = 1'b0;
  logic [15:0] start_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  opcode_out;
  logic [15:0] command_offset;
  logic [15:0] operand_offset;
  logic [15:0] operand_length;
  logic [15:0] next_offset;

  command_tracker tracker;
  int burst_left = 0;
  int hold_request = 0;
  int items_sent = 0;
  int items_used = 0;
  int sizes_used = 0;
  bit restart = 1'b0;

  script_instruction_length_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .code_byte(code_byte),
    .begin_req(begin_req),
    .start_offset(start_offset),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .opcode_out(opcode_out),
    .command_offset(command_offset),
    .operand_offset(operand_offset),
    .operand_length(operand_length),
    .next_offset(next_offset)
  );

  always #1 clk = ~clk;

  // Offer one code byte and wait for its transaction; the sender may idle between bursts.
  task automatic send_code_byte(input logic [7:0] b, input logic bg, input logic [15:0] so);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    end
    in_valid = 1'b1;
    code_byte = b;
    begin_req = bg;
    start_offset = so;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.note_code_byte(b, bg, so)) items_used++;
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Wait until every expected command has been reported and the pipeline is empty.
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write code_size while the block is idle.
  task automatic set_code_size(input logic [15:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = 16'($urandom);
    tracker.code_size = v;
    sizes_used++;
  endtask

  // Start offset for a begin request, biased toward the end of the code.
  function automatic logic [15:0] pick_start();
    int unsigned sz;
    int unsigned r;
    sz = tracker.code_size;
    r = $urandom_range(0, 15);
    if (sz == 0 || r == 0) return 16'($urandom);
    if (r < 5 && sz > 40) return 16'($urandom_range(sz - 40, sz - 1));
    return 16'($urandom_range(0, sz - 1));
  endfunction

  // Opcode with extra weight on the string forms and a few invalid ones.
  function automatic logic [7:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) return TEXT_OPS[$urandom_range(0, 6)];
    if (r < 8) return OP_CHOICE;
    if (r == 8) return 8'($urandom_range(OPCODE_COUNT, 255));
    return 8'($urandom_range(0, OPCODE_COUNT - 1));
  endfunction

  // Send one command with random operands; a truncated one is cut short.
  task automatic send_command(input bit truncate);
    logic [7:0] op;
    logic [7:0] body[$];
    int unsigned form;
    int unsigned texts;
    int unsigned keep;
    bit bg;
    bg = restart || (tracker.phase == PH_IDLE) || ($urandom_range(0, 24) == 0);
    restart = truncate;
    op = pick_opcode();
    if (op < OPCODE_COUNT) begin
      form = OPERAND_FORM[op[6:0]];
      if (form == FORM_STRING || form == FORM_CHOICE) begin
        repeat (text_prefix(op)) body.push_back(8'($urandom));
        texts = (form == FORM_CHOICE) ? 2 : 1;
        repeat (texts) begin
          repeat ($urandom_range(0, 7)) body.push_back(8'($urandom_range(1, 255)));
          body.push_back(8'h00);
        end
        if (form == FORM_CHOICE) repeat (CHOICE_ADDR_BYTES) body.push_back(8'($urandom));
      end else begin
        repeat (form) body.push_back(8'($urandom));
      end
    end
    if (truncate && body.size() > 0) begin
      keep = $urandom_range(0, body.size() - 1);
      while (body.size() > keep) void'(body.pop_back());
    end
    send_code_byte(op, bg, bg ? pick_start() : 16'($urandom));
    // Stop once the command has failed or finished.
    foreach (body[i]) begin
      if (tracker.phase != PH_IDLE && tracker.phase != PH_OPCODE)
        send_code_byte(body[i], 1'b0, 16'($urandom));
    end
  endtask

  // Compare every accepted result transaction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_command(status, opcode_out, command_offset, operand_offset,
                            operand_length, next_offset);
  end

  // Receiver: switches between stall patterns and takes long hold-off requests.
  initial begin : receiver
    rx_mode_t mode;
    int mode_left;
    int hold_left;
    int tick;
    mode = RX_ALWAYS;
    mode_left = 100;
    hold_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_RANDOM: out_ready = 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready = (tick % 4) == 0;
          default: out_ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase_no;
    int target;
    int unsigned r;
    logic [15:0] sz;
    tracker = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: code_size still at its reset value of zero.
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(OP_NO_OPERANDS, 1'b1, 16'h0000);
    set_code_size(16'd100);

    // Opcode without operands, then the first invalid opcode chained after it.
    send_code_byte(OP_NO_OPERANDS, 1'b1, 16'd10);
    send_code_byte(OP_FIRST_BAD, 1'b0, 16'hFFFF);
    send_code_byte(8'hFF, 1'b1, 16'd20);
    // Fixed operands, prefix and first choice text all past the code end.
    send_code_byte(OP_LONG_FIXED, 1'b1, 16'd90);
    send_code_byte(OP_TEXT_PRE2, 1'b1, 16'd97);
    send_code_byte(OP_CHOICE, 1'b1, 16'd99);
    // Text that runs into the code end without a terminator.
    send_code_byte(OP_TEXT, 1'b1, 16'd98);
    send_code_byte(8'h41, 1'b0, 16'h0000);
    // First choice text ending exactly at the code end.
    send_code_byte(OP_CHOICE, 1'b1, 16'd98);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    // Choice address that would run past the code end.
    send_code_byte(OP_CHOICE, 1'b1, 16'd96);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    // Four-byte prefix holding zeros, then a complete choice with empty texts.
    send_code_byte(OP_TEXT_PRE4, 1'b1, 16'd40);
    repeat (4) send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(OP_CHOICE, 1'b0, 16'h0000);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(8'h00, 1'b0, 16'h0000);
    send_code_byte(8'hFF, 1'b0, 16'hFFFF);
    // Highest start offset: the operand offset wraps to zero.
    send_code_byte(OP_FIXED8, 1'b1, 16'hFFFF);
    // code_size shrinks while a text is open.
    send_code_byte(OP_TEXT, 1'b1, 16'd10);
    send_code_byte(8'h71, 1'b0, 16'h0000);
    set_code_size(16'd13);
    send_code_byte(8'h72, 1'b0, 16'h0000);

    // Random phases, each under its own code_size.
    for (phase_no = 0; phase_no < SIZE_PHASES; phase_no++) begin
      r = $urandom_range(0, 3);
      case (phase_no)
        0: sz = 16'hFFFF;
        1: sz = 16'd0;
        2: sz = 16'd1;
        default: begin
          case (r)
            0: sz = 16'($urandom_range(2, 40));
            1: sz = 16'($urandom_range(41, 600));
            2: sz = 16'($urandom_range(601, 65535));
            default: sz = 16'hFFFF - 16'($urandom_range(0, 3));
          endcase
        end
      endcase
      set_code_size(sz);
      if (phase_no == 4) hold_request = HOLD_CYCLES;
      target = items_used + RANDOM_ITEMS / SIZE_PHASES;
      while (items_used < target) begin
        r = $urandom_range(0, 99);
        if (r < 78) send_command(1'b0);
        else if (r < 90) send_command(1'b1);
        else send_code_byte(8'($urandom), $urandom_range(0, 3) == 0, pick_start());
      end
    end

    drain();
    if (tracker.expected.size() != 0)
      tracker.report($sformatf("%0d expected commands never reported",
                               tracker.expected.size()));
    $display("Covered %0d code bytes (%0d decoded) under %0d code_size settings.",
             items_sent, items_used, sizes_used);
    $display("Checked %0d commands: %0d ok, %0d invalid opcode, %0d past code end.",
             tracker.checked, tracker.status_seen[0], tracker.status_seen[1],
             tracker.status_seen[2]);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- script_instruction_length_decoder_core.f -----
rtl/core/sild_pkg.sv
rtl/core/sild_step.sv
rtl/core/script_instruction_length_decoder_core.sv
test/command_tracker_pkg.sv
test/script_instruction_length_decoder_core_tb.sv
